// File: rtl/polynomial_from_roots_macros.svh
// Assertion macros for the polynomial expansion block.
`ifndef POLYNOMIAL_FROM_ROOTS_MACROS_SVH
`define POLYNOMIAL_FROM_ROOTS_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define PFR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfr assertion failed");

// Check that cons holds in the cycle after ante.
`define PFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfr assertion failed");

`else

`define PFR_ASSERT_SAME(lbl, ante, cons)
`define PFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/pfr_pkg.sv
// Shared types and constants for the polynomial expansion block.
package pfr_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int DEPTH      = MAX_DEGREE + 1;
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
  localparam int POWER_W    = 5;
  localparam int ROOT_W     = 32;
  localparam int COEF_W     = 64;
  localparam int TERM_W     = 80;

  typedef struct packed {
    logic signed [ROOT_W-1:0] root;
    logic                     last_root;
  } root_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [POWER_W-1:0]       power;
    logic                     final_coefficient;
    logic                     overflow;
  } coef_item_t;

endpackage

// File: rtl/polynomial_from_roots.sv
// Polynomial expansion: one root per transaction, coefficients streamed out on the last root.
// Each root is applied coefficient by coefficient (load, extend, low and high multiply, sum,
// accumulate) on the single shared 32x32 multiplier, used twice per coefficient; input is
// stalled meanwhile. At degree 0 the load step is skipped, as the gain needs no RAM read.
// Output: each coefficient is read from the RAM, then loaded into the output once it is free.
// A root past the maximum degree leaves the coefficients unchanged and only marks overflow.
// Reset clears degree and overflow and sets gain to 1.0; the RAM needs no clearing pass.
`include "polynomial_from_roots_macros.svh"

module polynomial_from_roots (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               root_valid,
  output logic               root_stall,
  input  pfr_pkg::root_item_t root_item,
  output logic               coef_valid,
  input  logic               coef_stall,
  output pfr_pkg::coef_item_t coef_item
);
  import pfr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_EXT    = 4'd2;
  localparam logic [3:0] S_MULLO  = 4'd3;
  localparam logic [3:0] S_MULHI  = 4'd4;
  localparam logic [3:0] S_SUM    = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_OUT_RD = 4'd7;
  localparam logic [3:0] S_OUT_LD = 4'd8;

  localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_DEGREE);

  // Control registers
  logic [3:0]        state;
  logic [DEG_W-1:0]  degree;
  logic [DEG_W-1:0]  idx;
  logic              ovf_seen;
  logic [31:0]       gain;

  // Datapath registers
  logic              root_neg;
  logic [31:0]       root_mag;
  logic              last_flag;
  logic [COEF_W-1:0] coef;
  logic [COEF_W-1:0] addend;
  logic [63:0]       prod_lo;
  logic [63:0]       prod_hi;
  logic [TERM_W-1:0] term_mag;

  // RAM ports
  logic              ram_we;
  logic [DEG_W-1:0]  ram_waddr;
  logic [COEF_W-1:0] ram_wdata;
  logic [DEG_W-1:0]  ram_raddr;
  logic [COEF_W-1:0] ram_rdata;

  // Combinational helpers
  logic              root_accept;
  logic              out_free;
  logic [COEF_W-1:0] gain_ext;
  logic [31:0]       root_mag_next;
  logic [COEF_W-1:0] coef_mag;
  logic [31:0]       mul_a;
  logic [63:0]       mul_p;
  logic [95:0]       prod_sum;
  logic              term_pos;
  logic [TERM_W:0]   acc_a;
  logic [TERM_W:0]   acc_m;
  logic [TERM_W:0]   acc_res;
  logic              acc_sat;
  logic [COEF_W-1:0] acc_out;

  assign root_stall  = (state != S_IDLE);
  assign root_accept = root_valid && !root_stall;
  assign out_free    = !coef_valid || !coef_stall;

  assign gain_ext      = {{(COEF_W - 40){gain[31]}}, gain, 8'b0};
  assign root_mag_next = root_item.root[31] ? (32'd0 - root_item.root) : root_item.root;

  // Shared multiplier: low half of the coefficient magnitude, then the high half
  assign coef_mag = coef[COEF_W-1] ? (COEF_W'(0) - coef) : coef;
  assign mul_a    = (state == S_MULLO) ? coef_mag[31:0] : coef_mag[63:32];
  assign mul_p    = {32'b0, mul_a} * {32'b0, root_mag};

  // Recombine the partial products and round half away from zero
  assign prod_sum = {prod_hi, 32'b0} + {32'b0, prod_lo} + 96'h8000;

  // Exact add or subtract of the rounded term, then clamp to 64 bits
  assign term_pos = root_neg ^ coef[COEF_W-1];
  assign acc_a    = {{(TERM_W + 1 - COEF_W){addend[COEF_W-1]}}, addend};
  assign acc_m    = {1'b0, term_mag};
  assign acc_res  = term_pos ? (acc_a + acc_m) : (acc_a - acc_m);
  assign acc_sat  = (acc_res[TERM_W:COEF_W-1] != '0) && (acc_res[TERM_W:COEF_W-1] != '1);
  assign acc_out  = !acc_sat ? acc_res[COEF_W-1:0]
                  : (acc_res[TERM_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                     : {1'b0, {(COEF_W-1){1'b1}}});

  // Select the RAM read address
  always_comb begin
    unique case (state)
      S_IDLE:  ram_raddr = degree;
      S_MULLO: ram_raddr = (idx == '0) ? '0 : DEG_W'(idx - 1'b1);
      default: ram_raddr = idx;
    endcase
  end

  // Select the RAM write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = acc_out;
    unique case (state)
      S_IDLE: begin
        ram_we    = root_accept && (degree == '0);
        ram_waddr = '0;
        ram_wdata = gain_ext;
      end
      S_EXT: begin
        ram_we    = (degree < DEG_MAX);
        ram_waddr = DEG_W'(degree + 1'b1);
        ram_wdata = coef;
      end
      S_ACC: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pfr_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      degree     <= '0;
      idx        <= '0;
      ovf_seen   <= 1'b0;
      gain       <= 32'h0001_0000;
      coef_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        gain <= cfg_data;
      end
      // Raise valid on a new coefficient, drop it once the transaction is taken
      if ((state == S_OUT_LD) && out_free) begin
        coef_valid <= 1'b1;
      end else if (!coef_stall) begin
        coef_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (root_accept) begin
            state <= (degree == '0) ? S_EXT : S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_EXT;
        end
        S_EXT: begin
          if (degree < DEG_MAX) begin
            idx   <= degree;
            state <= S_MULLO;
          end else begin
            ovf_seen <= 1'b1;
            idx      <= '0;
            state    <= last_flag ? S_OUT_RD : S_IDLE;
          end
        end
        S_MULLO: begin
          state <= S_MULHI;
        end
        S_MULHI: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_ACC;
        end
        S_ACC: begin
          ovf_seen <= ovf_seen | acc_sat;
          if (idx == '0) begin
            degree <= DEG_W'(degree + 1'b1);
            state  <= last_flag ? S_OUT_RD : S_IDLE;
          end else begin
            idx   <= DEG_W'(idx - 1'b1);
            state <= S_MULLO;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          if (out_free) begin
            if (idx == degree) begin
              degree   <= '0;
              ovf_seen <= 1'b0;
              idx      <= '0;
              state    <= S_IDLE;
            end else begin
              idx   <= DEG_W'(idx + 1'b1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (root_accept) begin
      root_neg  <= root_item.root[31];
      root_mag  <= root_mag_next;
      last_flag <= root_item.last_root;
      if (degree == '0) begin
        coef <= gain_ext;
      end
    end
    if (state == S_LOAD) begin
      coef <= ram_rdata;
    end
    if (state == S_MULLO) begin
      prod_lo <= mul_p;
    end
    if (state == S_MULHI) begin
      prod_hi <= mul_p;
      addend  <= (idx == '0) ? '0 : ram_rdata;
    end
    if (state == S_SUM) begin
      term_mag <= prod_sum[95:16];
    end
    if (state == S_ACC) begin
      coef <= addend;
    end
    if ((state == S_OUT_LD) && out_free) begin
      coef_item.coefficient       <= ram_rdata;
      coef_item.power             <= POWER_W'(idx);
      coef_item.final_coefficient <= (idx == degree);
      coef_item.overflow          <= ovf_seen;
    end
  end

  `PFR_ASSERT_SAME(a_degree_bound, 1'b1, degree <= DEG_MAX)
  `PFR_ASSERT_SAME(a_idx_in_poly, state == S_MULLO, idx <= degree)
  `PFR_ASSERT_NEXT(a_excess_root, (state == S_EXT) && (degree == DEG_MAX), ovf_seen)
  `PFR_ASSERT_NEXT(a_run_clears, (state == S_OUT_LD) && out_free && (idx == degree), (state == S_IDLE) && (degree == '0) && !ovf_seen && coef_valid)

endmodule

// File: rtl/pfr_ram.sv
// Generic single-port-write, registered-read RAM.
module pfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 17
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read data every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
